FILE: design/assert_macros.svh
// Assertion macros shared by the checker files of the d-pad remapper.
// Depends on nothing; included by design/crdr_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every clock edge except while reset is applied.
`define CRDR_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Checked at every clock edge, reset included.
`define CRDR_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

FILE: design/crdr_pkg.sv
// Shared types, constants and helpers of the camera-relative d-pad remapper.
// Depends on nothing; used by crdr_rotate and the core.
package crdr_pkg;

    localparam int KEYS_W = 16;
    localparam int YAW_W  = 16;
    localparam int CTX_W  = 2;

    typedef logic [KEYS_W-1:0] keys_t;
    typedef logic [YAW_W-1:0]  yaw_t;
    typedef logic [CTX_W-1:0]  ctx_t;
    typedef logic [1:0]        quad_t;
    typedef logic [2:0]        bitpos_t;

    // Context codes
    localparam ctx_t CTX_INACTIVE = 2'd0;
    localparam ctx_t CTX_CAMERA   = 2'd1;

    localparam keys_t DIR_MASK         = 16'h00F0;
    localparam keys_t INACTIVE_RELEASE = 16'h03FF;
    localparam yaw_t  QUAD_OFFSET      = 16'h2000;

    // Bit position of each direction in compass order: up, right, down, left
    localparam bitpos_t COMPASS_POS [4] = '{3'd6, 3'd4, 3'd7, 3'd5};

    // Nearest quarter turn: (yaw + 1/8 turn) >> 14, wrapping
    function automatic quad_t yaw_quadrant(input yaw_t yaw);
        yaw_t sum;
        begin
            sum = yaw + QUAD_OFFSET;
            return sum[YAW_W-1 -: 2];
        end
    endfunction

endpackage

FILE: design/crdr_rotate.sv
// Rotates the held directions of an active-low key word by a quarter-turn count.
// Depends on crdr_pkg.
module crdr_rotate
(
    input  crdr_pkg::keys_t keys,
    input  crdr_pkg::quad_t quadrant,
    output crdr_pkg::keys_t rotated
);

    logic [3:0] pressed;
    logic [3:0] moved;

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            pressed[i] = ~keys[crdr_pkg::COMPASS_POS[i]];
        end
        // a press at index i lands on index i - quadrant
        for (int j = 0; j < 4; j++)
        begin
            moved[j] = pressed[2'(j) + quadrant];
        end
        rotated = keys | crdr_pkg::DIR_MASK;
        for (int j = 0; j < 4; j++)
        begin
            if (moved[j])
            begin
                rotated[crdr_pkg::COMPASS_POS[j]] = 1'b0;
            end
        end
    end

endmodule

FILE: design/camera_relative_dpad_remapper_core.sv
// Top level of the camera-relative d-pad remapper: input stage, remap logic,
// state flags and output register. Depends on crdr_pkg and crdr_rotate.
//
// Usage
//   Slave stream (s_axis_*) carries one controller sample per beat: the
//   active-low key word and the camera yaw in tdata, the yaw flag and the
//   interaction context in tuser. Master stream (m_axis_*) returns one
//   remapped active-low key word per input beat, in order.
//   Path: an accepted input beat passes the input register, then the result
//   register, on its way to its output beat.
//   Throughput: one beat per cycle while m_axis_tready is high. The input
//   register advances whenever the result register is empty or being taken,
//   so a new sample is accepted in the same cycle that a finished result leaves.
//   Stall: while m_axis_tready is low the result holds; one more sample can
//   sit in the input register, after which s_axis_tready drops.
//   Reset (rst_n low, asynchronous): both stages empty, directions blanked
//   until released, no quadrant latched, remembered context inactive.
//   The held-press state (blanking, latched quadrant, last context) updates
//   when a sample moves from the input register to the result register.
module camera_relative_dpad_remapper_core
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [15:0] key_bits, [31:16] yaw_angle
    input  logic [2:0]  s_axis_tuser,   // [0] yaw_valid, [2:1] context_code
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata    // [15:0] mapped_keys
);

    // Input stage
    logic             in_valid_reg;
    crdr_pkg::keys_t  in_keys_reg;
    crdr_pkg::yaw_t   in_yaw_reg;
    logic             in_yaw_ok_reg;
    crdr_pkg::ctx_t   in_ctx_reg;

    // Result stage
    logic             out_valid_reg;
    crdr_pkg::keys_t  out_keys_reg;
    crdr_pkg::keys_t  out_keys_next;

    // Held-press state
    logic             seen_first_reg,    seen_first_next;
    logic             need_neutral_reg,  need_neutral_next;
    logic             quad_latched_reg,  quad_latched_next;
    crdr_pkg::ctx_t   last_context_reg,  last_context_next;
    crdr_pkg::quad_t  held_quadrant_reg, held_quadrant_next;

    logic             advance;
    logic             in_take;
    logic             held;
    logic             changed;
    logic             nn_mid;
    logic             ql_mid;
    crdr_pkg::quad_t  rot_quad;
    crdr_pkg::keys_t  rotated;

    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign in_take       = s_axis_tvalid && s_axis_tready;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_keys_reg;

    // any of the four direction bits pressed (low)
    assign held    = ((~in_keys_reg) & crdr_pkg::DIR_MASK) != '0;
    assign changed = in_ctx_reg != last_context_reg;

    // press goes on in the same context with a quadrant already latched
    assign ql_mid   = held && quad_latched_reg && !changed;
    // quadrant the camera branch rotates by: the kept one, or the one latched now
    assign rot_quad = ql_mid ? held_quadrant_reg : crdr_pkg::yaw_quadrant(in_yaw_reg);

    crdr_rotate u_rotate
    (
        .keys     (in_keys_reg),
        .quadrant (rot_quad),
        .rotated  (rotated)
    );

    always_comb
    begin
        // context switch mid-press blanks the directions; release clears all
        nn_mid = held && (need_neutral_reg || (seen_first_reg && changed));

        seen_first_next    = 1'b1;
        last_context_next  = in_ctx_reg;
        need_neutral_next  = nn_mid;
        quad_latched_next  = ql_mid;
        held_quadrant_next = held_quadrant_reg;
        out_keys_next      = in_keys_reg;

        priority if (in_ctx_reg == crdr_pkg::CTX_INACTIVE)
        begin
            need_neutral_next = nn_mid || held;
            out_keys_next     = in_keys_reg | crdr_pkg::INACTIVE_RELEASE;
        end
        else if (nn_mid)
        begin
            out_keys_next = in_keys_reg | crdr_pkg::DIR_MASK;
        end
        else if (in_ctx_reg != crdr_pkg::CTX_CAMERA || !in_yaw_ok_reg)
        begin
            out_keys_next = in_keys_reg;
        end
        else
        begin
            // camera context: latch quadrant at start of press, then rotate
            if (held && !ql_mid)
            begin
                held_quadrant_next = crdr_pkg::yaw_quadrant(in_yaw_reg);
                quad_latched_next  = 1'b1;
            end
            out_keys_next = rotated;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg      <= 1'b0;
            out_valid_reg     <= 1'b0;
            seen_first_reg    <= 1'b0;
            need_neutral_reg  <= 1'b1;
            quad_latched_reg  <= 1'b0;
            last_context_reg  <= crdr_pkg::CTX_INACTIVE;
            held_quadrant_reg <= '0;
        end
        else
        begin
            if (in_take)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                out_valid_reg     <= 1'b1;
                seen_first_reg    <= seen_first_next;
                need_neutral_reg  <= need_neutral_next;
                quad_latched_reg  <= quad_latched_next;
                last_context_reg  <= last_context_next;
                held_quadrant_reg <= held_quadrant_next;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_keys_reg   <= s_axis_tdata[15:0];
            in_yaw_reg    <= s_axis_tdata[31:16];
            in_yaw_ok_reg <= s_axis_tuser[0];
            in_ctx_reg    <= s_axis_tuser[2:1];
        end
        if (advance)
        begin
            out_keys_reg <= out_keys_next;
        end
    end

endmodule

FILE: design/crdr_checker.sv
// Port-level checks of the d-pad remapper core and the bind that attaches them.
// Depends on assert_macros.svh and camera_relative_dpad_remapper_core.
`include "assert_macros.svh"

module crdr_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata
);

    logic stall_beat;
    logic out_stall;
    logic ready_follows;

    // input beat taken while the output beat waits
    assign stall_beat    = s_axis_tvalid && s_axis_tready && m_axis_tvalid && !m_axis_tready;
    assign out_stall     = m_axis_tvalid && !m_axis_tready;
    assign ready_follows = s_axis_tready == m_axis_tready;

    // reset empties the result stage at once
    `CRDR_ASSERT_ALWAYS(a_reset_empty, clk, !rst_n |-> !m_axis_tvalid, "output valid in reset")

    // an empty result stage never back-pressures the input
    `CRDR_ASSERT_ALWAYS(a_ready_when_empty, clk, !m_axis_tvalid |-> s_axis_tready, "input stalled")

    // both stages full after a stalled beat: ready then follows the sink
    `CRDR_ASSERT(a_fill_on_stall, clk, rst_n, stall_beat |=> ready_follows, "input stage not full")

    // a stalled result beat holds
    `CRDR_ASSERT(a_out_hold, clk, rst_n, out_stall |=> m_axis_tvalid, "stalled output beat dropped")
    `CRDR_ASSERT(a_out_data, clk, rst_n, out_stall |=> $stable(m_axis_tdata), "stalled data moved")

endmodule

bind camera_relative_dpad_remapper_core crdr_checker u_crdr_checker (.*);
